FILE: src/tps_pkg.sv
`timescale 1ns / 1ps
// tps_pkg: shared constants, types and constant tables for the top-p token sampler
// depends on nothing; used by tps_weight and top_p_token_sampler

package tps_pkg;

   localparam int VOCAB_SIZE  = 131072;
   localparam int ADDR_W      = $clog2(VOCAB_SIZE);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int WEIGHT_BITS = 24;
   localparam int WT_W        = WEIGHT_BITS + 1;
   localparam int SUM_W       = WT_W + ADDR_W;
   localparam int TOKEN_W     = 17;
   localparam int KEPT_W      = 18;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 17;

   // log2(e) in Q.24
   localparam logic [24:0] LOG2E_Q24 = 25'd24204406;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GREEDY_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TEMP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUCLEUS     = 2'd2;

   // one stored entry: logit plus its vocabulary index
   typedef struct packed {
      logic [31:0]       value;
      logic [ADDR_W-1:0] index;
   } entry_type;

   typedef logic [15:0][31:0] root_tab_type;

   // integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] bit_v;
      x     = x_in;
      r     = '0;
      bit_v = 64'd1 << 62;
      for (int s = 0; s < 32; s++) begin
         if (bit_v > x) bit_v = bit_v >> 2;
      end
      for (int s = 0; s < 32; s++) begin
         if (bit_v != 0) begin
            if (x >= r + bit_v) begin
               x = x - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return r;
   endfunction

   // root j is 2^(-2^-(j+1)) in Q0.32
   function automatic root_tab_type build_roots();
      root_tab_type t;
      logic [63:0]  r;
      r    = isqrt64(64'd1 << 63);
      t[0] = r[31:0];
      for (int j = 1; j < 16; j++) begin
         r    = isqrt64({r[31:0], 32'd0});
         t[j] = r[31:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOTS = build_roots();

endpackage

FILE: src/tps_weight.sv
`timescale 1ns / 1ps
// tps_weight: iterative fixed-point exp((v - max) * inverse_temperature) unit
// depends on tps_pkg

module tps_weight (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               value,
   input  logic [31:0]               best_value,
   input  logic [15:0]               inverse_temperature,
   output logic                      done,
   output logic [tps_pkg::WT_W-1:0]  weight
);
   import tps_pkg::*;

   typedef enum logic [2:0] {W_IDLE, W_MT, W_MY, W_IT, W_FIN} wstate_type;

   wstate_type        state_ff;
   logic [31:0]       d_ff;
   logic [31:0]       t_ff;
   logic              zero_ff;
   logic [4:0]        n_ff;
   logic [15:0]       f_ff;
   logic [32:0]       acc_ff;
   logic [3:0]        j_ff;
   logic              done_ff;
   logic [WT_W-1:0]   weight_ff;

   logic [47:0] prod_t;
   logic [56:0] prod_y;
   logic [32:0] y_val;
   logic [64:0] prod_r;
   logic [5:0]  shamt;
   logic [32:0] shifted;

   // datapath products, one per stage
   always_comb begin
      prod_t  = {16'd0, d_ff} * {32'd0, inverse_temperature};
      prod_y  = {25'd0, t_ff} * {32'd0, LOG2E_Q24};
      y_val   = prod_y[56:24];
      prod_r  = {32'd0, acc_ff} * {33'd0, ROOTS[j_ff]};
      shamt   = 6'(32 - WEIGHT_BITS) + {1'b0, n_ff};
      shifted = acc_ff >> shamt;
   end

   // sequencer: difference, scale, log2 conversion, 16 root steps, shift
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == W_FIN);
         unique case (state_ff)
            W_IDLE: begin
               if (start) begin
                  d_ff     <= best_value - value;
                  state_ff <= W_MT;
               end
            end
            W_MT: begin
               t_ff     <= prod_t[39:8];
               zero_ff  <= |prod_t[47:40];
               state_ff <= W_MY;
            end
            W_MY: begin
               zero_ff  <= zero_ff | (y_val[32:16] >= 17'(WEIGHT_BITS));
               n_ff     <= y_val[20:16];
               f_ff     <= y_val[15:0];
               acc_ff   <= 33'h1_0000_0000;
               j_ff     <= '0;
               state_ff <= W_IT;
            end
            W_IT: begin
               if (f_ff[4'd15 - j_ff]) acc_ff <= prod_r[64:32];
               j_ff <= j_ff + 4'd1;
               if (j_ff == 4'd15) state_ff <= W_FIN;
            end
            W_FIN: begin
               weight_ff <= zero_ff ? '0 : shifted[WT_W-1:0];
               state_ff  <= W_IDLE;
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign weight = weight_ff;

endmodule

FILE: src/top_p_token_sampler.sv
`timescale 1ns / 1ps
// top_p_token_sampler: top level, logit memories, merge sort and nucleus selection
// depends on tps_pkg and tps_weight
//
// Usage: logits stream in on the req_ channel in vocabulary order, one per cycle
// while req_ready is high; req_last_logit marks the last, carrying req_uniform_draw.
// Each vector gives exactly one response on the rsp_ channel (token and kept count).
// Configuration writes on csr_ take effect at once; write only while idle.
// Greedy mode: the response is registered on the edge that takes the last request,
// so it is visible in the next cycle.
// Sampling mode: after the last request the block merge-sorts the stored entries
// between two memories, a pair of runs at a time on each of ceil(log2 n) passes,
// then makes three scans (total, nucleus, draw) through the shared exp unit, which
// finishes each entry before the scan moves on to the next.
// No request is taken during sorting and scanning.
// Reset clears counters, the state machine and the registers to greedy_mode 0,
// inverse_temperature 256, nucleus_mass 65536; memories need no clearing.
// A stalled receiver holds the response; non-last requests are still taken,
// a last request waits until the pending response is taken.

module top_p_token_sampler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     req_logit_value,
   input  logic                            req_last_logit,
   input  logic [31:0]                     req_uniform_draw,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tps_pkg::TOKEN_W-1:0]     rsp_token_index,
   output logic [tps_pkg::KEPT_W-1:0]      rsp_retained_count,
   input  logic                            csr_we,
   input  logic [tps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tps_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD, S_SEG, S_RD, S_WR, S_SRD, S_SWS, S_SWW, S_THR, S_DM1, S_DM2
   } state_type;
   typedef enum logic [1:0] {P_TOTAL, P_NUC, P_DRAW} pass_type;

   localparam int LO_W = SUM_W / 2;
   localparam int HI_W = SUM_W - LO_W;

   // configuration
   logic        greedy_ff;
   logic [15:0] inv_temp_ff;
   logic [16:0] mass_ff;

   // control
   state_type          state_ff;
   pass_type           pass_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [31:0]        best_ff;
   logic [ADDR_W-1:0]  best_idx_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   w_ff;
   logic [CNT_W-1:0]   lo_ff;
   logic [CNT_W-1:0]   mid_ff;
   logic [CNT_W-1:0]   hi_ff;
   logic [CNT_W-1:0]   a_ff;
   logic [CNT_W-1:0]   b_ff;
   logic [CNT_W-1:0]   k_ff;
   logic               sel_ff;
   logic [31:0]        draw_ff;
   logic [SUM_W-1:0]   total_ff;
   logic [SUM_W-1:0]   cum_ff;
   logic [SUM_W+16:0]  thr_ff;
   logic [LO_W+31:0]   dlo_ff;
   logic [SUM_W+31:0]  dprod_ff;
   logic [CNT_W-1:0]   kept_ff;
   logic [ADDR_W-1:0]  cur_idx_ff;
   logic               wstart_ff;

   // response register
   logic               rsp_valid_ff;
   logic [TOKEN_W-1:0] rsp_token_ff;
   logic [KEPT_W-1:0]  rsp_kept_ff;
   logic               rsp_valid_in;
   logic [TOKEN_W-1:0] rsp_token_in;
   logic [KEPT_W-1:0]  rsp_kept_in;

   // memories
   entry_type mem0_ff [VOCAB_SIZE];
   entry_type mem1_ff [VOCAB_SIZE];
   entry_type rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;

   logic              wr0_en, wr1_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         ra, rb;

   logic              req_fire, cnt_full, best_upd;
   logic [ADDR_W-1:0] best_idx_now;
   logic [CNT_W-1:0]  count_next;
   logic              take_a;
   logic [CNT_W:0]    lo_w_sum, lo_2w_sum, lo_next;
   logic [CNT_W-1:0]  w_dbl;
   logic              w_done;
   logic [WT_W-1:0]   w_val;
   logic [SUM_W-1:0]  cum_new;
   logic [CNT_W-1:0]  a_inc;
   logic              merge_done;
   logic              draw_hit;

   // exp unit
   tps_weight u_weight (
      .clock               (clock),
      .reset               (reset),
      .start               (wstart_ff),
      .value               (ra.value),
      .best_value          (best_ff),
      .inverse_temperature (inv_temp_ff),
      .done                (w_done),
      .weight              (w_val)
   );

   // load path and merge compare
   always_comb begin
      req_ready    = (state_ff == S_LOAD) &&
                     (!req_last_logit || !rsp_valid_ff || rsp_ready);
      req_fire     = req_valid && req_ready;
      cnt_full     = (count_ff == CNT_W'(VOCAB_SIZE));
      best_upd     = !cnt_full && ((count_ff == '0) ||
                     ($signed(req_logit_value) > $signed(best_ff)));
      best_idx_now = best_upd ? count_ff[ADDR_W-1:0] : best_idx_ff;
      count_next   = cnt_full ? count_ff : count_ff + 1'b1;
      ra           = sel_ff ? rd1a_ff : rd0a_ff;
      rb           = sel_ff ? rd1b_ff : rd0b_ff;
      take_a       = (a_ff < mid_ff) &&
                     ((b_ff >= hi_ff) || ($signed(ra.value) >= $signed(rb.value)));
      lo_w_sum     = {1'b0, lo_ff} + {1'b0, w_ff};
      lo_2w_sum    = {1'b0, lo_ff} + {w_ff, 1'b0};
      lo_next      = lo_2w_sum;
      w_dbl        = {w_ff[CNT_W-2:0], 1'b0};
      cum_new      = cum_ff + SUM_W'(w_val);
      a_inc        = a_ff + 1'b1;
      merge_done   = (k_ff + 1'b1 == hi_ff) && (lo_next >= {1'b0, n_ff}) &&
                     (w_dbl >= n_ff);
      draw_hit     = (dprod_ff < {cum_new, 32'd0}) || (a_inc == kept_ff);
   end

   // response register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_token_in = rsp_token_ff;
      rsp_kept_in  = rsp_kept_ff;
      if ((state_ff == S_LOAD) && req_fire && req_last_logit && greedy_ff) begin
         rsp_valid_in = 1'b1;
         rsp_token_in = TOKEN_W'(best_idx_now);
         rsp_kept_in  = KEPT_W'(1);
      end else if ((state_ff == S_SWW) && w_done && (pass_ff == P_DRAW) && draw_hit) begin
         rsp_valid_in = 1'b1;
         rsp_token_in = TOKEN_W'(cur_idx_ff);
         rsp_kept_in  = KEPT_W'(kept_ff);
      end
   end

   // memory write selection
   always_comb begin
      wr0_en  = 1'b0;
      wr1_en  = 1'b0;
      wr_addr = k_ff[ADDR_W-1:0];
      wr_data = take_a ? ra : rb;
      if (state_ff == S_LOAD) begin
         wr0_en          = req_fire && !cnt_full;
         wr_addr         = count_ff[ADDR_W-1:0];
         wr_data.value   = req_logit_value;
         wr_data.index   = count_ff[ADDR_W-1:0];
      end else if (state_ff == S_WR) begin
         wr0_en = sel_ff;
         wr1_en = !sel_ff;
      end
   end

   // memory ports: one write, two registered reads each
   always_ff @(posedge clock) begin
      if (wr0_en) mem0_ff[wr_addr] <= wr_data;
      if (wr1_en) mem1_ff[wr_addr] <= wr_data;
      rd0a_ff <= mem0_ff[a_ff[ADDR_W-1:0]];
      rd0b_ff <= mem0_ff[b_ff[ADDR_W-1:0]];
      rd1a_ff <= mem1_ff[a_ff[ADDR_W-1:0]];
      rd1b_ff <= mem1_ff[b_ff[ADDR_W-1:0]];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         greedy_ff   <= 1'b0;
         inv_temp_ff <= 16'd256;
         mass_ff     <= 17'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GREEDY_MODE: greedy_ff   <= csr_wdata[0];
            CSR_INV_TEMP:    inv_temp_ff <= csr_wdata[15:0];
            CSR_NUCLEUS:     mass_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // main sequencer: load, merge passes, three scans, response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         pass_ff      <= P_TOTAL;
         count_ff     <= '0;
         best_ff      <= '0;
         best_idx_ff  <= '0;
         sel_ff       <= 1'b0;
         wstart_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         a_ff         <= '0;
         b_ff         <= '0;
      end else begin
         wstart_ff    <= (state_ff == S_SWS);
         rsp_valid_ff <= rsp_valid_in;
         rsp_token_ff <= rsp_token_in;
         rsp_kept_ff  <= rsp_kept_in;
         unique case (state_ff)
            S_LOAD: begin
               if (req_fire) begin
                  if (req_last_logit) begin
                     count_ff    <= '0;
                     best_idx_ff <= '0;
                     draw_ff     <= req_uniform_draw;
                     n_ff        <= count_next;
                     if (greedy_ff) begin
                        best_ff <= '0;
                     end else begin
                        // keep best logit for the weight scans
                        if (best_upd) best_ff <= req_logit_value;
                        sel_ff <= 1'b0;
                        w_ff   <= CNT_W'(1);
                        lo_ff  <= '0;
                        if (count_next == CNT_W'(1)) begin
                           pass_ff  <= P_TOTAL;
                           total_ff <= '0;
                           a_ff     <= '0;
                           state_ff <= S_SRD;
                        end else begin
                           state_ff <= S_SEG;
                        end
                     end
                  end else begin
                     count_ff <= count_next;
                     if (best_upd) begin
                        best_ff     <= req_logit_value;
                        best_idx_ff <= best_idx_now;
                     end
                  end
               end
            end
            // set up one pair of runs
            S_SEG: begin
               mid_ff   <= (lo_w_sum < {1'b0, n_ff}) ? lo_w_sum[CNT_W-1:0] : n_ff;
               hi_ff    <= (lo_2w_sum < {1'b0, n_ff}) ? lo_2w_sum[CNT_W-1:0] : n_ff;
               a_ff     <= lo_ff;
               b_ff     <= (lo_w_sum < {1'b0, n_ff}) ? lo_w_sum[CNT_W-1:0] : n_ff;
               k_ff     <= lo_ff;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_WR;
            // write one merged entry, advance the run it came from
            S_WR: begin
               if (merge_done) a_ff <= '0;
               else if (take_a) a_ff <= a_inc;
               if (!take_a) b_ff <= b_ff + 1'b1;
               k_ff <= k_ff + 1'b1;
               if (k_ff + 1'b1 == hi_ff) begin
                  if (lo_next >= {1'b0, n_ff}) begin
                     sel_ff <= !sel_ff;
                     w_ff   <= w_dbl;
                     lo_ff  <= '0;
                     if (w_dbl >= n_ff) begin
                        pass_ff  <= P_TOTAL;
                        total_ff <= '0;
                        state_ff <= S_SRD;
                     end else begin
                        state_ff <= S_SEG;
                     end
                  end else begin
                     lo_ff    <= lo_next[CNT_W-1:0];
                     state_ff <= S_SEG;
                  end
               end else begin
                  state_ff <= S_RD;
               end
            end
            // scans over the sorted entries
            S_SRD: state_ff <= S_SWS;
            S_SWS: begin
               cur_idx_ff <= ra.index;
               state_ff   <= S_SWW;
            end
            S_SWW: begin
               if (w_done) begin
                  unique case (pass_ff)
                     P_TOTAL: begin
                        total_ff <= total_ff + SUM_W'(w_val);
                        if (a_inc == n_ff) begin
                           state_ff <= S_THR;
                        end else begin
                           a_ff     <= a_inc;
                           state_ff <= S_SRD;
                        end
                     end
                     P_NUC: begin
                        if ((a_inc < n_ff) &&
                            ({1'b0, cum_new, 16'd0} < thr_ff)) begin
                           cum_ff   <= cum_new;
                           a_ff     <= a_inc;
                           state_ff <= S_SRD;
                        end else begin
                           cum_ff   <= cum_new;
                           kept_ff  <= a_inc;
                           state_ff <= S_DM1;
                        end
                     end
                     P_DRAW: begin
                        if (draw_hit) begin
                           best_ff  <= '0;
                           state_ff <= S_LOAD;
                        end else begin
                           cum_ff   <= cum_new;
                           a_ff     <= a_inc;
                           state_ff <= S_SRD;
                        end
                     end
                     default: state_ff <= S_LOAD;
                  endcase
               end
            end
            // nucleus threshold mass * total
            S_THR: begin
               thr_ff   <= {42'd0, mass_ff} * {17'd0, total_ff};
               pass_ff  <= P_NUC;
               cum_ff   <= '0;
               a_ff     <= '0;
               state_ff <= S_SRD;
            end
            // draw * kept total in two partial products
            S_DM1: begin
               dlo_ff   <= {32'd0, cum_ff[LO_W-1:0]} * {LO_W'(0), draw_ff};
               state_ff <= S_DM2;
            end
            S_DM2: begin
               dprod_ff <= ({(SUM_W+32-HI_W-32)'(0), ({32'd0, cum_ff[SUM_W-1:LO_W]} *
                            {HI_W'(0), draw_ff})} << LO_W) + (SUM_W+32)'(dlo_ff);
               pass_ff  <= P_DRAW;
               cum_ff   <= '0;
               a_ff     <= '0;
               state_ff <= S_SRD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_token_index    = rsp_token_ff;
   assign rsp_retained_count = rsp_kept_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VOCAB_SIZE))
      else $error("item count above vocabulary size");

   a_merge_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (k_ff >= lo_ff) && (k_ff < hi_ff))
      else $error("merge write outside its run");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWS) |-> (a_ff < n_ff))
      else $error("scan index past vector end");

   a_kept_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kept_ff != '0))
      else $error("response with empty nucleus");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> !wr0_en || (state_ff == S_WR))
      else $error("load write outside load phase");

endmodule
